FILE: hdl/tet_pkg.sv
// ----------------------------------------------------------------------------
// tet_pkg: shared types and codes for the tick event timer
// Item and result records, item kinds, timer modes and register indexes.
// ----------------------------------------------------------------------------
package tet_pkg;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 32;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STAGGER   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET_DELAY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ARM       = 2'd3;

    // Timer modes (any other code acts as single shot)
    localparam logic [MODE_W-1:0] MODE_SINGLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MULTIPLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPEAT   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_FIRINGS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETIRE_DONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ACTIVE  = 3'd4;

    typedef logic [COUNT_W-1:0] t_count;

    // One input item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        t_count            amount;
    } t_item;

    // One result item
    typedef struct packed {
        logic   fired;
        logic   finished;
        logic   retired;
        logic   running;
        t_count ticks_left;
    } t_result;

    // Configuration write bundle
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

FILE: hdl/tick_event_timer.sv
// ----------------------------------------------------------------------------
// tick_event_timer: tick-driven event timer
// Single, multiple and repeat firing modes on a countdown driven by ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries items: tick, stagger add, set
//   new delay, arm. Output channel (o_valid / i_stall) returns one result per
//   item: fired, finished, retired, running and the remaining tick count.
//   A transfer happens at a clock edge with valid high and stall low.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
//   must write them only while no item is in flight, which the block does not
//   enforce. Writes to unknown indexes are dropped. An item passes the input
//   register, then the result register. Throughput: one item per cycle while
//   the receiver does not stall; the countdown update is one subtract/compare
//   pass between the two registers. When the receiver stalls, the result
//   register holds and the input register takes one more item; o_stall rises
//   only when both are full. Reset (synchronous, active low) clears all
//   registers and timer state to zero and empties both stages.
// ----------------------------------------------------------------------------
module tick_event_timer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [tet_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tet_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Item channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [tet_pkg::KIND_W-1:0]        i_kind,
    input  logic [tet_pkg::COUNT_W-1:0]       i_amount,
    // Result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_fired,
    output logic                              o_finished,
    output logic                              o_retired,
    output logic                              o_running,
    output logic [tet_pkg::COUNT_W-1:0]       o_ticks_left
);
    import tet_pkg::*;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_free;
    logic    step;
    t_cfg_wr cfg;
    t_result core_result;
    t_result out_result;

    assign in_item.kind   = i_kind;
    assign in_item.amount = i_amount;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // Held item advances whenever the result register has room
    assign step = held_valid && out_free;

    tet_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .i_take  (step),
        .o_stall (o_stall),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    tet_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .i_item   (held_item),
        .o_result (core_result)
    );

    tet_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (core_result),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_fired      = out_result.fired;
    assign o_finished   = out_result.finished;
    assign o_retired    = out_result.retired;
    assign o_running    = out_result.running;
    assign o_ticks_left = out_result.ticks_left;

endmodule

FILE: hdl/tet_in_stage.sv
// ----------------------------------------------------------------------------
// tet_in_stage: input register
// Captures one item per transfer and holds it until the core takes it.
// ----------------------------------------------------------------------------
module tet_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tet_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_stall,
    output logic           o_valid,
    output tet_pkg::t_item o_item
);
    import tet_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    // Stall only when the held item is not leaving this cycle
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: hdl/tet_core.sv
// ----------------------------------------------------------------------------
// tet_core: timer state and single-pass update
// Holds configuration and countdown state, applies one item per step and
// forms its result.
// ----------------------------------------------------------------------------
module tet_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tet_pkg::t_cfg_wr i_cfg,
    input  logic             i_step,
    input  tet_pkg::t_item   i_item,
    output tet_pkg::t_result o_result
);
    import tet_pkg::*;

    // Configuration
    logic [MODE_W-1:0] r_mode;
    t_count            r_extra;
    logic              r_retire_cfg;

    // Timer state
    t_count r_delay_left,   n_delay_left;
    t_count r_delay_reload, n_delay_reload;
    t_count r_firings_left, n_firings_left;
    logic   r_active,       n_active;
    logic   r_retired,      n_retired;

    logic   fired;
    logic   finished;
    t_count firing_reload;

    assign firing_reload = (r_mode == MODE_MULTIPLE) ? r_extra : '0;

    // Next state for one item
    always_comb begin
        n_delay_left   = r_delay_left;
        n_delay_reload = r_delay_reload;
        n_firings_left = r_firings_left;
        n_active       = r_active;
        n_retired      = r_retired;
        fired          = 1'b0;
        finished       = 1'b0;
        if (!r_retired) begin
            case (i_item.kind)
                KIND_TICK: begin
                    if (r_active) begin
                        if (r_delay_left > t_count'(1)) begin
                            n_delay_left = r_delay_left - t_count'(1);
                        end else begin
                            fired = 1'b1;
                            if (r_mode == MODE_REPEAT) begin
                                n_delay_left = r_delay_reload;
                            end else if (r_firings_left != '0) begin
                                n_delay_left   = r_delay_reload;
                                n_firings_left = r_firings_left - t_count'(1);
                            end else begin
                                finished = 1'b1;
                                n_active = 1'b0;
                                if (r_retire_cfg) begin
                                    n_retired = 1'b1;
                                end else begin
                                    n_delay_left   = r_delay_reload;
                                    n_firings_left = firing_reload;
                                end
                            end
                        end
                    end
                end
                KIND_STAGGER: begin
                    n_delay_left = r_delay_left + i_item.amount;
                end
                KIND_SET_DELAY: begin
                    n_delay_left   = i_item.amount;
                    n_delay_reload = i_item.amount;
                end
                KIND_ARM: begin
                    n_active = 1'b1;
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end
    end

    // Result of this step
    assign o_result.fired      = fired;
    assign o_result.finished   = finished;
    assign o_result.retired    = n_retired;
    assign o_result.running    = n_active && !n_retired;
    assign o_result.ticks_left = n_delay_left;

    // State update: register writes must arrive only while no item is in flight; this block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_SINGLE;
            r_extra        <= '0;
            r_retire_cfg   <= 1'b0;
            r_delay_left   <= '0;
            r_delay_reload <= '0;
            r_firings_left <= '0;
            r_active       <= 1'b0;
            r_retired      <= 1'b0;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_MODE: begin
                    r_mode <= i_cfg.data[MODE_W-1:0];
                    r_firings_left <= (i_cfg.data[MODE_W-1:0] == MODE_MULTIPLE)
                                      ? r_extra : '0;
                end
                CFG_INITIAL_DELAY: begin
                    r_delay_left   <= i_cfg.data[COUNT_W-1:0];
                    r_delay_reload <= i_cfg.data[COUNT_W-1:0];
                end
                CFG_EXTRA_FIRINGS: begin
                    r_extra <= i_cfg.data[COUNT_W-1:0];
                    r_firings_left <= (r_mode == MODE_MULTIPLE)
                                      ? i_cfg.data[COUNT_W-1:0] : '0;
                end
                CFG_RETIRE_DONE: begin
                    r_retire_cfg <= i_cfg.data[0];
                end
                CFG_START_ACTIVE: begin
                    r_active <= i_cfg.data[0];
                end
                default: begin
                    r_retire_cfg <= r_retire_cfg;
                end
            endcase
        end else if (i_step) begin
            r_delay_left   <= n_delay_left;
            r_delay_reload <= n_delay_reload;
            r_firings_left <= n_firings_left;
            r_active       <= n_active;
            r_retired      <= n_retired;
        end
    end

    // Retirement only ends at reset
    a_retired_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_retired |=> r_retired)
        else $error("retired flag cleared without reset");

    // Repeat mode never deactivates on a tick
    a_repeat_keeps_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_cfg.we && !r_retired && r_active && r_mode == MODE_REPEAT
         && i_item.kind == KIND_TICK) |=> r_active)
        else $error("repeat timer went inactive");

    // A new delay also becomes the reload value
    a_set_delay_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_cfg.we && !r_retired && i_item.kind == KIND_SET_DELAY)
        |=> (r_delay_reload == $past(i_item.amount)
             && r_delay_left == $past(i_item.amount)))
        else $error("set delay did not load both counters");

    // A finish is always a firing
    a_finish_fires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && finished) |-> (fired && !n_active))
        else $error("finish without firing");

endmodule

FILE: hdl/tet_out_stage.sv
// ----------------------------------------------------------------------------
// tet_out_stage: result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module tet_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tet_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output tet_pkg::t_result o_result
);
    import tet_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Room for a new result when empty or when the held one leaves now
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: test/tick_event_timer_checker.sv
// ----------------------------------------------------------------------------
// tick_event_timer_checker: result predictor and scoreboard for the timer
// Watches register writes and both item channels, keeps its own copy of the
// timer registers and countdown state, predicts one result per accepted item
// and compares every result transfer field by field against the oldest
// prediction. Reports mismatches, outstanding predictions and run counts.
// ----------------------------------------------------------------------------
module tick_event_timer_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Register writes
    input  logic                              i_cfg_we,
    input  logic [tet_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tet_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Item channel
    input  logic                              i_item_valid,
    input  logic                              i_item_stall,
    input  logic [tet_pkg::KIND_W-1:0]        i_kind,
    input  logic [tet_pkg::COUNT_W-1:0]       i_amount,
    // Result channel
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  logic                              i_fired,
    input  logic                              i_finished,
    input  logic                              i_retired,
    input  logic                              i_running,
    input  logic [tet_pkg::COUNT_W-1:0]       i_ticks_left,
    // Status toward the testbench top
    output int                                o_pending,
    output int                                o_errors,
    output int                                o_result_count,
    output int                                o_fire_count,
    output int                                o_finish_count
);

    import tet_pkg::*;

    // Register copies
    logic [MODE_W-1:0] cur_mode;
    t_count            cur_extra;
    logic              cur_retire;

    // Timer state copy
    t_count left_q;
    t_count reload_q;
    t_count shots_left;
    logic   active_q;
    logic   retired_q;

    // Predicted results, oldest first
    t_result timer_results_q[$];

    int mismatches   = 0;
    int result_total = 0;
    int fire_total   = 0;
    int finish_total = 0;
    int pending_q    = 0;

    assign o_errors       = mismatches;
    assign o_result_count = result_total;
    assign o_fire_count   = fire_total;
    assign o_finish_count = finish_total;
    assign o_pending      = pending_q;

    // Firing count that a reload restores: only multiple mode has extras
    function automatic t_count shot_reload();
        return (cur_mode == MODE_MULTIPLE) ? cur_extra : '0;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_MODE: begin
                cur_mode   = d[MODE_W-1:0];
                shots_left = shot_reload();
            end
            CFG_INITIAL_DELAY: begin
                left_q   = d;
                reload_q = d;
            end
            CFG_EXTRA_FIRINGS: begin
                cur_extra  = d;
                shots_left = shot_reload();
            end
            CFG_RETIRE_DONE:  cur_retire = d[0];
            CFG_START_ACTIVE: active_q   = d[0];
            default: ;  // unknown index: dropped
        endcase
    endfunction

    // One item through the timer; updates the state copy
    function automatic t_result advance_timer(logic [KIND_W-1:0] k, t_count a);
        t_result r;
        r = '0;
        if (!retired_q) begin
            case (k)
                KIND_TICK: begin
                    if (active_q) begin
                        if (left_q > 1) begin
                            left_q = left_q - 1;
                        end else begin
                            r.fired = 1'b1;
                            if (cur_mode == MODE_REPEAT) begin
                                left_q = reload_q;
                            end else if (shots_left != 0) begin
                                left_q     = reload_q;
                                shots_left = shots_left - 1;
                            end else begin
                                // last firing: retire or park with reload
                                r.finished = 1'b1;
                                active_q   = 1'b0;
                                if (cur_retire) begin
                                    retired_q = 1'b1;
                                end else begin
                                    left_q     = reload_q;
                                    shots_left = shot_reload();
                                end
                            end
                        end
                    end
                end
                KIND_STAGGER: left_q = left_q + a;
                KIND_SET_DELAY: begin
                    left_q   = a;
                    reload_q = a;
                end
                KIND_ARM: active_q = 1'b1;
                default: ;
            endcase
        end
        r.retired    = retired_q;
        r.running    = active_q && !retired_q;
        r.ticks_left = left_q;
        return r;
    endfunction

    function automatic void check_field(string name, t_count want, t_count got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Sample both channels at the clock edge
    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            cur_mode   = MODE_SINGLE;
            cur_extra  = '0;
            cur_retire = 1'b0;
            left_q     = '0;
            reload_q   = '0;
            shots_left = '0;
            active_q   = 1'b0;
            retired_q  = 1'b0;
            timer_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                apply_register(i_cfg_idx, i_cfg_data);
            end
            // result transfer against oldest prediction
            if (i_res_valid && !i_res_stall) begin
                got = {i_fired, i_finished, i_retired, i_running, i_ticks_left};
                result_total++;
                if (timer_results_q.size() == 0) begin
                    $error("result transfer with no item outstanding");
                    mismatches++;
                end else begin
                    want = timer_results_q.pop_front();
                    check_field("fired", t_count'(want.fired), t_count'(got.fired));
                    check_field("finished", t_count'(want.finished),
                                t_count'(got.finished));
                    check_field("retired", t_count'(want.retired),
                                t_count'(got.retired));
                    check_field("running", t_count'(want.running),
                                t_count'(got.running));
                    check_field("ticks_left", want.ticks_left, got.ticks_left);
                    if (want.fired) fire_total++;
                    if (want.finished) finish_total++;
                end
            end
            // item transfer: predict its result
            if (i_item_valid && !i_item_stall) begin
                timer_results_q.push_back(advance_timer(i_kind, i_amount));
            end
        end
        pending_q <= timer_results_q.size();
    end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the tick event timer
// Drives register setups and item streams into the timer: a directed pass
// over countdown edges, wraps and every mode, then randomized setups with
// random idle gaps, back-pressure holds and a final retirement. Results are
// checked by the checker instance; this module decides the verdict.
// ----------------------------------------------------------------------------
module testbench;

    import tet_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 60;
    localparam int RANDOM_PHASES = 18;
    localparam int PHASE_ITEMS   = 60;
    localparam int DRAIN_CYCLES  = 10;

    // Mode code outside the named ones; acts as single shot
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef enum logic [1:0] {RX_RANDOM, RX_FREE, RX_HOLD} t_rx_style;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    logic [KIND_W-1:0]     kind       = KIND_TICK;
    t_count                amount     = '0;
    logic                  res_valid;
    logic                  res_stall  = 1'b0;
    logic                  fired;
    logic                  finished;
    logic                  retired;
    logic                  running;
    t_count                ticks_left;

    int pending;
    int errors;
    int result_count;
    int fire_count;
    int finish_count;

    int        cycle_count = 0;
    int        items_sent  = 0;
    int        setups      = 0;
    bit        tx_steady   = 1'b0;
    t_rx_style rx_style    = RX_RANDOM;

    tick_event_timer dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_valid      (item_valid),
        .o_stall      (item_stall),
        .i_kind       (kind),
        .i_amount     (amount),
        .o_valid      (res_valid),
        .i_stall      (res_stall),
        .o_fired      (fired),
        .o_finished   (finished),
        .o_retired    (retired),
        .o_running    (running),
        .o_ticks_left (ticks_left)
    );

    tick_event_timer_checker watcher (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_item_valid   (item_valid),
        .i_item_stall   (item_stall),
        .i_kind         (kind),
        .i_amount       (amount),
        .i_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .i_fired        (fired),
        .i_finished     (finished),
        .i_retired      (retired),
        .i_running      (running),
        .i_ticks_left   (ticks_left),
        .o_pending      (pending),
        .o_errors       (errors),
        .o_result_count (result_count),
        .o_fire_count   (fire_count),
        .o_finish_count (finish_count)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Idle gap lengths: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    function automatic t_count pick_delay();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70) return $urandom_range(6, 0);
        if (r < 85) return $urandom_range(40, 7);
        if (r < 90) return '1;
        if (r < 95) return $urandom;
        return '1 - $urandom_range(3, 0);
    endfunction

    function automatic t_count pick_extra();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70) return $urandom_range(3, 0);
        if (r < 90) return $urandom_range(12, 4);
        if (r < 95) return '1;
        return $urandom;
    endfunction

    // Small forward offsets, small wrapping subtractions, or anything
    function automatic t_count pick_stagger();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60) return $urandom_range(5, 0);
        if (r < 80) return '1 - $urandom_range(4, 0);
        return $urandom;
    endfunction

    // Result side: random stalls, free running, or long holds
    initial begin : result_sink
        int hold;
        forever begin
            case (rx_style)
                RX_HOLD: hold = HOLD_CYCLES;
                RX_FREE: hold = 0;
                default: hold = pick_gap();
            endcase
            if (hold > 0) begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
    end

    // Register write; the enable stays up until end_writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(posedge clk);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        setups++;
    endtask

    task automatic write_unused_regs();
        for (int i = CFG_START_ACTIVE + 1; i < 2 ** CFG_IDX_W; i++) begin
            write_reg(CFG_IDX_W'(i), $urandom);
        end
    endtask

    // One item transfer, with an optional idle gap before it
    task automatic issue(input logic [KIND_W-1:0] k, input t_count a);
        int g;
        g = tx_steady ? 0 : pick_gap();
        if (g > 0) begin
            item_valid <= 1'b0;
            kind       <= $urandom_range(3, 0);
            amount     <= $urandom;
            repeat (g) @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= k;
        amount     <= a;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_idle();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // New register values in a rotating order; retiring is only allowed
    // in repeat mode here, since that mode never finishes
    task automatic random_setup();
        logic [MODE_W-1:0]     m;
        logic [CFG_DATA_W-1:0] d;
        int rot;
        int r;
        r = $urandom_range(9, 0);
        m = (r == 0) ? MODE_SPARE : MODE_W'($urandom_range(MODE_REPEAT, MODE_SINGLE));
        rot = $urandom_range(5, 0);
        for (int slot = 0; slot < 6; slot++) begin
            d = $urandom;
            case ((slot + rot) % 6)
                0: begin
                    d[MODE_W-1:0] = m;
                    write_reg(CFG_MODE, d);
                end
                1: if ($urandom_range(4, 0) != 0) write_reg(CFG_INITIAL_DELAY, pick_delay());
                2: if ($urandom_range(4, 0) != 0) write_reg(CFG_EXTRA_FIRINGS, pick_extra());
                3: begin
                    d[0] = (m == MODE_REPEAT) ? 1'($urandom_range(1, 0)) : 1'b0;
                    write_reg(CFG_RETIRE_DONE, d);
                end
                4: if ($urandom_range(4, 0) != 0) begin
                    d[0] = ($urandom_range(9, 0) < 7);
                    write_reg(CFG_START_ACTIVE, d);
                end
                default: if ($urandom_range(9, 0) < 3) begin
                    write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1,
                                                        CFG_START_ACTIVE + 1)), d);
                end
            endcase
        end
        end_writes();
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99, 0);
        if (r < 68) issue(KIND_TICK, $urandom);
        else if (r < 80) issue(KIND_ARM, $urandom);
        else if (r < 90) issue(KIND_STAGGER, pick_stagger());
        else issue(KIND_SET_DELAY, pick_delay());
    endtask

    initial begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all registers at reset, countdown edges and wraps
        issue(KIND_TICK, '0);                 // inactive tick
        issue(KIND_TICK, '1);
        issue(KIND_ARM, '1);
        issue(KIND_TICK, '0);                 // fires at zero, finishes
        issue(KIND_SET_DELAY, '1);
        issue(KIND_ARM, '0);
        issue(KIND_TICK, '0);                 // counts down from the top
        issue(KIND_STAGGER, 32'd2);           // wraps to zero
        issue(KIND_TICK, '1);
        issue(KIND_SET_DELAY, 32'd1);
        issue(KIND_ARM, '0);
        issue(KIND_TICK, '0);                 // fires at one
        issue(KIND_SET_DELAY, 32'd3);
        issue(KIND_STAGGER, '1);              // wrapping subtract
        issue(KIND_ARM, '0);
        issue(KIND_TICK, '0);
        issue(KIND_TICK, '0);
        issue(KIND_STAGGER, '0);
        wait_idle();

        // Multiple mode with one extra firing, unknown indexes dropped
        write_reg(CFG_MODE, {30'h3FFF_FFFF, MODE_MULTIPLE});
        write_reg(CFG_EXTRA_FIRINGS, 32'd1);
        write_reg(CFG_INITIAL_DELAY, 32'd2);
        write_reg(CFG_RETIRE_DONE, 32'hFFFF_FFFE);
        write_reg(CFG_START_ACTIVE, 32'd1);
        write_unused_regs();
        end_writes();
        repeat (4) issue(KIND_TICK, $urandom);
        wait_idle();

        // Repeat mode never finishes
        write_reg(CFG_MODE, {30'd0, MODE_REPEAT});
        write_reg(CFG_INITIAL_DELAY, 32'd1);
        write_reg(CFG_START_ACTIVE, 32'hFFFF_FFFF);
        end_writes();
        repeat (3) issue(KIND_TICK, $urandom);
        wait_idle();

        // Spare mode code behaves as single shot
        write_reg(CFG_MODE, 32'hFFFF_FFFF);
        end_writes();
        repeat (2) issue(KIND_TICK, $urandom);
        wait_idle();

        // Random setups; one style of idling per phase
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_setup();
            case (p % 4)
                1: begin
                    tx_steady = 1'b1;
                    rx_style <= RX_FREE;
                end
                2: begin
                    tx_steady = 1'b1;
                    rx_style <= RX_HOLD;
                end
                default: begin
                    tx_steady = 1'b0;
                    rx_style <= RX_RANDOM;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
                if ($urandom_range(49, 0) == 0) wait_idle();
            end
            wait_idle();
        end

        // Retirement: single shot with retire set, then the timer ignores all
        tx_steady = 1'b0;
        rx_style <= RX_RANDOM;
        write_reg(CFG_MODE, {30'h2AAA_AAAA, MODE_SINGLE});
        write_reg(CFG_EXTRA_FIRINGS, 32'd0);
        write_reg(CFG_INITIAL_DELAY, 32'd2);
        write_reg(CFG_RETIRE_DONE, 32'd1);
        write_reg(CFG_START_ACTIVE, 32'd1);
        end_writes();
        repeat (3) issue(KIND_TICK, $urandom);
        repeat (15) random_item();
        wait_idle();
        // register writes still land, but the timer stays retired
        write_reg(CFG_MODE, {30'd0, MODE_MULTIPLE});
        write_reg(CFG_EXTRA_FIRINGS, 32'd2);
        write_reg(CFG_INITIAL_DELAY, 32'd1);
        write_reg(CFG_START_ACTIVE, 32'd1);
        end_writes();
        repeat (12) random_item();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Timer run: %0d items sent, %0d results checked, %0d firings, %0d finishes.",
                 items_sent, result_count, fire_count, finish_count);
        $display("Covered %0d register setups, output holds, idle pauses and retirement.",
                 setups);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
